>>> hdl/csd_pkg.sv
// Shared types, segment table and digit helpers for the seven-segment clock.
package csd_pkg;

    localparam logic [7:0] SEG_BLANK      = 8'hFF;
    localparam logic [7:0] DOT_CLEAR_MASK = 8'h7F;
    localparam logic [7:0] INVERT_MASK    = 8'hFF;

    localparam logic [5:0] SEC_WRAP  = 6'd59;
    localparam logic [5:0] MIN_WRAP  = 6'd59;
    localparam logic [4:0] HOUR_WRAP = 5'd23;

    localparam int NUM_DIGITS = 4;

    // Active-low patterns: a 0 bit lights a segment, bit 7 is the dot
    localparam logic [7:0] SEG_TABLE [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
        8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [1:0] dot;
    } t_clock_time;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } t_bcd;

    typedef logic [NUM_DIGITS-1:0][7:0] t_digits;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        if (d < 4'd10) begin
            return SEG_TABLE[d];
        end else begin
            return SEG_BLANK;
        end
    endfunction

    // Split a value below 60 into decimal digits by compare and subtract
    function automatic t_bcd split_decimal(input logic [5:0] v);
        t_bcd r;
        if (v >= 6'd50) begin
            r.tens = 3'd5;
            r.ones = 4'(v - 6'd50);
        end else if (v >= 6'd40) begin
            r.tens = 3'd4;
            r.ones = 4'(v - 6'd40);
        end else if (v >= 6'd30) begin
            r.tens = 3'd3;
            r.ones = 4'(v - 6'd30);
        end else if (v >= 6'd20) begin
            r.tens = 3'd2;
            r.ones = 4'(v - 6'd20);
        end else if (v >= 6'd10) begin
            r.tens = 3'd1;
            r.ones = 4'(v - 6'd10);
        end else begin
            r.tens = 3'd0;
            r.ones = v[3:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/csd_time.sv
// Time-of-day counters: dot position, seconds, minutes and hours.
module csd_time (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_tick,
    output csd_pkg::t_clock_time  o_time
);

    csd_pkg::t_clock_time r_time;
    csd_pkg::t_clock_time n_time;

    always_comb begin
        n_time = r_time;
        if (i_tick) begin
            n_time.dot = r_time.dot + 2'd1;
            // Dot wraps from last digit to first: one second has gone by
            if (r_time.dot == 2'd3) begin
                if (r_time.second >= csd_pkg::SEC_WRAP) begin
                    n_time.second = '0;
                    if (r_time.minute >= csd_pkg::MIN_WRAP) begin
                        n_time.minute = '0;
                        if (r_time.hour >= csd_pkg::HOUR_WRAP) begin
                            n_time.hour = '0;
                        end else begin
                            n_time.hour = r_time.hour + 5'd1;
                        end
                    end else begin
                        n_time.minute = r_time.minute + 6'd1;
                    end
                end else begin
                    n_time.second = r_time.second + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_advance) begin
            r_time <= n_time;
        end
    end

    assign o_time = n_time;

endmodule

>>> hdl/csd_render.sv
// Segment rendering of HH:MM with leading-zero blanking, dot and inversion.
module csd_render (
    input  csd_pkg::t_clock_time  i_time,
    input  logic                  i_invert,
    output csd_pkg::t_digits      o_digits
);

    csd_pkg::t_bcd    hour_bcd;
    csd_pkg::t_bcd    min_bcd;
    csd_pkg::t_digits raw;

    always_comb begin
        hour_bcd = csd_pkg::split_decimal({1'b0, i_time.hour});
        min_bcd  = csd_pkg::split_decimal(i_time.minute);

        // Blank a leading hour zero
        raw[0] = (hour_bcd.tens == 3'd0) ? csd_pkg::SEG_BLANK
                                         : csd_pkg::seg_of({1'b0, hour_bcd.tens});
        raw[1] = csd_pkg::seg_of(hour_bcd.ones);
        raw[2] = csd_pkg::seg_of({1'b0, min_bcd.tens});
        raw[3] = csd_pkg::seg_of(min_bcd.ones);

        for (int i = 0; i < csd_pkg::NUM_DIGITS; i++) begin
            o_digits[i] = raw[i];
            if (i_time.dot == 2'(i)) begin
                o_digits[i] = o_digits[i] & csd_pkg::DOT_CLEAR_MASK;
            end
            if (i_invert) begin
                o_digits[i] = o_digits[i] ^ csd_pkg::INVERT_MASK;
            end
        end
    end

endmodule

>>> hdl/clock_seven_segment_display_top.sv
// Top level of the HH:MM seven-segment clock: input register, update, result register.
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+-----------------------------------------
//  input    | i_in_valid  | o_in_stall   | i_tick
//  result   | o_out_valid | i_out_stall  | o_digit_*, o_hours_now, o_minutes_now,
//           |             |              | o_seconds_now, o_dot_index
//  config   | i_cfg_we    | -            | i_cfg_data (invert_output)
//
// One transaction per cycle unless the result is stalled; an accepted input is held
// in the input register, then loaded into the result register, where it can be taken.
// The time update and segment lookup sit between the input and the result register.
// Synchronous reset clears time to 00:00:00, dot to digit 0 and inversion off.
// A stalled result holds; the input register still takes a transaction while it is free.
module clock_seven_segment_display_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_tick,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_digit_hour_tens,
    output logic [7:0]  o_digit_hour_ones,
    output logic [7:0]  o_digit_minute_tens,
    output logic [7:0]  o_digit_minute_ones,
    output logic [4:0]  o_hours_now,
    output logic [5:0]  o_minutes_now,
    output logic [5:0]  o_seconds_now,
    output logic [1:0]  o_dot_index
);

    logic                  r_in_valid;
    logic                  r_in_tick;
    logic                  r_invert;
    logic                  r_out_valid;
    csd_pkg::t_digits      r_digits;
    csd_pkg::t_clock_time  r_time_out;

    logic                  in_accept;
    logic                  out_load;
    csd_pkg::t_clock_time  time_next;
    csd_pkg::t_digits      digits;

    // Move the held transaction on when the result register is free or being drained
    assign out_load   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    csd_time u_time (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (out_load),
        .i_tick    (r_in_tick),
        .o_time    (time_next)
    );

    csd_render u_render (
        .i_time   (time_next),
        .i_invert (r_invert),
        .o_digits (digits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_invert    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_invert <= i_cfg_data;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_tick <= i_tick;
        end
        if (out_load) begin
            r_digits   <= digits;
            r_time_out <= time_next;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_digit_hour_tens   = r_digits[0];
    assign o_digit_hour_ones   = r_digits[1];
    assign o_digit_minute_tens = r_digits[2];
    assign o_digit_minute_ones = r_digits[3];
    assign o_hours_now         = r_time_out.hour;
    assign o_minutes_now       = r_time_out.minute;
    assign o_seconds_now       = r_time_out.second;
    assign o_dot_index         = r_time_out.dot;

endmodule

>>> dv/tb_clock_seven_segment_display_top.sv
// Self-checking testbench for the HH:MM seven-segment clock top level.
`timescale 1ns / 100ps

module tb_clock_seven_segment_display_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PIPE_LATENCY   = 2;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int MAX_PRINTED    = 40;

    // Active-low digit glyphs, bit 7 is the dot
    localparam logic [7:0] GLYPHS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
        8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };
    localparam logic [7:0] BLANK_GLYPH = 8'hFF;

    localparam int PHASE_IDLE_PCT  [4] = '{0, 48, 0, 29};
    localparam int PHASE_STALL_PCT [4] = '{0, 0, 48, 29};

    typedef struct packed {
        logic [7:0] hour_tens;
        logic [7:0] hour_ones;
        logic [7:0] minute_tens;
        logic [7:0] minute_ones;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] dot;
    } t_display;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_tick      = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_digit_hour_tens;
    logic [7:0] o_digit_hour_ones;
    logic [7:0] o_digit_minute_tens;
    logic [7:0] o_digit_minute_ones;
    logic [4:0] o_hours_now;
    logic [5:0] o_minutes_now;
    logic [5:0] o_seconds_now;
    logic [1:0] o_dot_index;

    // Predicted clock state and display setting
    logic [4:0] clk_hr     = '0;
    logic [5:0] clk_min    = '0;
    logic [5:0] clk_sec    = '0;
    logic [1:0] clk_dot    = '0;
    logic       invert_on  = 1'b0;

    t_display   pending_displays [$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int idle_cycles    = 0;
    int mismatch_count = 0;
    int items_sent     = 0;
    int ticks_sent     = 0;
    int displays_checked = 0;
    int invert_writes  = 0;
    int day_wraps      = 0;

    clock_seven_segment_display_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_tick              (i_tick),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_digit_hour_tens   (o_digit_hour_tens),
        .o_digit_hour_ones   (o_digit_hour_ones),
        .o_digit_minute_tens (o_digit_minute_tens),
        .o_digit_minute_ones (o_digit_minute_ones),
        .o_hours_now         (o_hours_now),
        .o_minutes_now       (o_minutes_now),
        .o_seconds_now       (o_seconds_now),
        .o_dot_index         (o_dot_index)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending_displays.size());
            $display("tb_clock_seven_segment_display_top: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
        end
    endtask

    // Advance the clock on a tick, then render the four digits
    task automatic advance_and_render(input logic tick);
        t_display   d;
        logic [7:0] dig [4];
        if (tick) begin
            clk_dot = clk_dot + 2'd1;
            if (clk_dot == 2'd0) begin
                clk_sec = clk_sec + 6'd1;
                if (clk_sec == 6'd60) begin
                    clk_sec = '0;
                    clk_min = clk_min + 6'd1;
                    if (clk_min == 6'd60) begin
                        clk_min = '0;
                        clk_hr  = clk_hr + 5'd1;
                        if (clk_hr == 5'd24) begin
                            clk_hr = '0;
                            day_wraps++;
                        end
                    end
                end
            end
        end
        dig[0] = (clk_hr >= 5'd10) ? GLYPHS[clk_hr / 10] : BLANK_GLYPH;
        dig[1] = GLYPHS[clk_hr % 10];
        dig[2] = GLYPHS[clk_min / 10];
        dig[3] = GLYPHS[clk_min % 10];
        // Light the dot, even on a blanked leading zero
        dig[clk_dot][7] = 1'b0;
        if (invert_on) begin
            for (int i = 0; i < 4; i++) begin
                dig[i] = ~dig[i];
            end
        end
        d.hour_tens   = dig[0];
        d.hour_ones   = dig[1];
        d.minute_tens = dig[2];
        d.minute_ones = dig[3];
        d.hours       = clk_hr;
        d.minutes     = clk_min;
        d.seconds     = clk_sec;
        d.dot         = clk_dot;
        pending_displays.push_back(d);
    endtask

    always @(posedge i_clk) begin
        t_display want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_displays.size() == 0) begin
                report_mismatch("result with no expected display pending");
            end else begin
                want = pending_displays.pop_front();
                displays_checked++;
                check_field("digit_hour_tens", o_digit_hour_tens, want.hour_tens);
                check_field("digit_hour_ones", o_digit_hour_ones, want.hour_ones);
                check_field("digit_minute_tens", o_digit_minute_tens, want.minute_tens);
                check_field("digit_minute_ones", o_digit_minute_ones, want.minute_ones);
                check_field("hours_now", 8'(o_hours_now), 8'(want.hours));
                check_field("minutes_now", 8'(o_minutes_now), 8'(want.minutes));
                check_field("seconds_now", 8'(o_seconds_now), 8'(want.seconds));
                check_field("dot_index", 8'(o_dot_index), 8'(want.dot));
            end
        end
    end

    task automatic send_item(input logic tick);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_tick     <= tick;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        advance_and_render(tick);
        items_sent++;
        if (tick) begin
            ticks_sent++;
        end
    endtask

    // Drop valid and hold until every expected display has come back
    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_displays.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_invert(input logic value);
        wait_results_done();
        repeat (PIPE_LATENCY + 1) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        invert_on = value;
        invert_writes++;
    endtask

    task automatic test_power_up();
        idle_pct  = 0;
        stall_pct = 0;
        // Blank leading zero carries the dot
        send_item(1'b0);
        send_item(1'b0);
        repeat (3) send_item(1'b1);
        // Dot wraps and the first second goes by
        send_item(1'b1);
        send_item(1'b0);
    endtask

    task automatic test_inverted_display();
        write_invert(1'b1);
        send_item(1'b0);
        repeat (4) send_item(1'b1);
        write_invert(1'b0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            write_invert(phase[0] ? 1'b0 : 1'b1);
            idle_pct  = PHASE_IDLE_PCT[phase];
            stall_pct = PHASE_STALL_PCT[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_results_done();
                end
                send_item($urandom_range(0, 99) < 75);
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // Stop on the last quarter second of a minute, flip the polarity, roll over
    task automatic test_minute_rollover();
        idle_pct  = 0;
        stall_pct = 0;
        write_invert(1'b0);
        while (!(clk_sec == 6'd59 && clk_dot == 2'd3)) begin
            send_item(1'b1);
        end
        write_invert(1'b1);
        repeat (8) send_item(1'b1);
        write_invert(1'b0);
        repeat (8) send_item(1'b1);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_up();
        test_inverted_display();
        test_random_traffic();
        test_minute_rollover();

        wait_results_done();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (pending_displays.size() != 0) begin
            report_mismatch($sformatf("%0d expected displays never arrived",
                                      pending_displays.size()));
        end

        $display("covered %0d transactions (%0d ticks), %0d displays checked",
                 items_sent, ticks_sent, displays_checked);
        $display("%0d polarity writes, %0d day wraps, %0d mismatches",
                 invert_writes, day_wraps, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_clock_seven_segment_display_top: PASS");
        end else begin
            $display("tb_clock_seven_segment_display_top: FAIL");
        end
        $finish;
    end

endmodule
